// ===== hw/rtl/edfjt_pkg.sv =====
// Shared types and codes for the earliest-deadline-first job table.
package edfjt_pkg;

  localparam int SLOT_W = 5;
  localparam int OCC_W  = 6;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_PICK   = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;
  localparam logic [1:0] MODE_POP    = 2'd3;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_FULL   = 2'd1;
  localparam logic [1:0] STAT_EMPTY  = 2'd2;
  localparam logic [1:0] STAT_NOSLOT = 2'd3;

  typedef struct packed {
    logic [1:0]        mode;
    logic signed [7:0] task_tag;
    logic [1:0]        io_kind;
    logic [30:0]       deadline;
    logic [15:0]       request_count;
    logic [4:0]        slot;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [4:0]        job_slot;
    logic signed [7:0] job_task;
    logic [1:0]        job_kind;
    logic [30:0]       job_deadline;
    logic [15:0]       remaining;
    logic [5:0]        occupancy;
  } rsp_t;

  typedef struct packed {
    logic [30:0]       deadline;
    logic [15:0]       count;
    logic signed [7:0] tag;
    logic [1:0]        kind;
    logic [15:0]       stamp;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic capture;
    logic issue;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last;
    logic out_free;
  } ctrl_sts_t;

endpackage

// ===== hw/rtl/edfjt_ctrl.sv =====
// Sequencer for the job table: accept, scan, drain, commit; remove skips scan and drain.
module edfjt_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  logic [1:0]            mode,
  input  edfjt_pkg::ctrl_sts_t  sts,
  output edfjt_pkg::ctrl_cmd_t  cmd
);
  import edfjt_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.capture = 1'b1;
          // remove needs no scan
          state_next = (mode == MODE_REMOVE) ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.issue = 1'b1;
        if (sts.last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        // hold until the result register is free
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/edfjt_dp.sv =====
// Datapath of the job table: slot memory, valid bits, scan compare and result register.
module edfjt_dp #(
  parameter int SLOTS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  edfjt_pkg::req_t       req_item,
  input  edfjt_pkg::ctrl_cmd_t  cmd,
  output edfjt_pkg::ctrl_sts_t  sts,
  output logic                  res_valid,
  input  logic                  res_ready,
  output edfjt_pkg::rsp_t       res_item
);
  import edfjt_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int TW = $clog2(SLOTS + 1);
  localparam int XW = (IW > SLOT_W) ? IW : SLOT_W;

  req_t             held;
  logic [SLOTS-1:0] valid;
  entry_t           mem [SLOTS];
  logic [IW-1:0]    cnt;
  entry_t           rd_data;
  logic [IW-1:0]    rd_idx;
  logic             rd_vld;
  logic             rd_live;
  logic             found;
  logic [IW-1:0]    best_idx;
  entry_t           best;
  logic [15:0]      best_age;
  logic [15:0]      next_stamp;
  logic [TW-1:0]    total;

  logic [15:0]      rd_age;
  logic             take;
  rsp_t             rsp;
  logic             wr_en;
  entry_t           wr_entry;
  logic             set_en;
  logic             clr_en;
  logic [IW-1:0]    tgt;
  logic             stamp_inc;
  logic [TW-1:0]    total_next;
  logic [XW-1:0]    slot_x;
  logic             in_range;
  logic [15:0]      rem;

  assign rd_age   = next_stamp - rd_data.stamp;
  assign slot_x   = XW'(held.slot);
  assign in_range = (int'(held.slot) < SLOTS);
  assign rem      = (best.count != 16'd0) ? best.count - 16'd1 : 16'd0;

  assign sts.last     = (cnt == IW'(SLOTS - 1));
  assign sts.out_free = !res_valid || res_ready;

  // Scan compare on the slot read in the previous cycle.
  always_comb begin
    take = 1'b0;
    case (held.mode)
      MODE_INSERT: take = !rd_vld && !found;
      MODE_PICK: begin
        take = rd_vld && (!found || rd_data.deadline < best.deadline ||
                (rd_data.deadline == best.deadline && rd_age < best_age));
      end
      MODE_POP: take = rd_vld && (!found || rd_age > best_age);
      default:  take = 1'b0;
    endcase
  end

  always_comb begin
    rsp        = '0;
    rsp.status = STAT_OK;
    wr_en      = 1'b0;
    wr_entry   = best;
    set_en     = 1'b0;
    clr_en     = 1'b0;
    tgt        = best_idx;
    stamp_inc  = 1'b0;
    total_next = total;
    case (held.mode)
      MODE_INSERT: begin
        if (!found) begin
          rsp.status = STAT_FULL;
        end else begin
          wr_en          = 1'b1;
          wr_entry.deadline = held.deadline;
          wr_entry.count = held.request_count;
          wr_entry.tag   = held.task_tag;
          wr_entry.kind  = held.io_kind;
          wr_entry.stamp = next_stamp;
          set_en         = 1'b1;
          stamp_inc      = 1'b1;
          total_next     = total + TW'(1);
          rsp.job_slot   = SLOT_W'(best_idx);
        end
      end
      MODE_PICK: begin
        if (!found) begin
          rsp.status = STAT_EMPTY;
        end else begin
          wr_en            = 1'b1;
          wr_entry.count   = rem;
          rsp.job_slot     = SLOT_W'(best_idx);
          rsp.job_task     = best.tag;
          rsp.job_kind     = best.kind;
          rsp.job_deadline = best.deadline;
          rsp.remaining    = rem;
        end
      end
      MODE_REMOVE: begin
        tgt = slot_x[IW-1:0];
        if (!in_range || !valid[tgt]) begin
          rsp.status = STAT_NOSLOT;
        end else begin
          clr_en     = 1'b1;
          total_next = total - TW'(1);
        end
      end
      default: begin
        if (!found) begin
          rsp.status = STAT_EMPTY;
        end else begin
          clr_en           = 1'b1;
          total_next       = total - TW'(1);
          rsp.job_slot     = SLOT_W'(best_idx);
          rsp.job_task     = best.tag;
          rsp.job_kind     = best.kind;
          rsp.job_deadline = best.deadline;
          rsp.remaining    = best.count;
        end
      end
    endcase
    rsp.occupancy = OCC_W'(total_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      next_stamp <= 16'd0;
      total      <= '0;
      res_valid  <= 1'b0;
      rd_live    <= 1'b0;
      found      <= 1'b0;
      cnt        <= '0;
    end else begin
      rd_live <= cmd.issue;
      if (cmd.capture) begin
        cnt   <= '0;
        found <= 1'b0;
      end else begin
        if (cmd.issue) begin
          cnt <= cnt + IW'(1);
        end
        if (rd_live && take) begin
          found <= 1'b1;
        end
      end
      if (cmd.commit) begin
        if (set_en) begin
          valid[tgt] <= 1'b1;
        end
        if (clr_en) begin
          valid[tgt] <= 1'b0;
        end
        if (stamp_inc) begin
          next_stamp <= next_stamp + 16'd1;
        end
        total <= total_next;
      end
      if (cmd.commit) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      held <= req_item;
    end
    if (cmd.issue) begin
      rd_data <= mem[cnt];
      rd_idx  <= cnt;
      rd_vld  <= valid[cnt];
    end
    if (rd_live && take) begin
      best_idx <= rd_idx;
      best     <= rd_data;
      best_age <= rd_age;
    end
    if (cmd.commit && wr_en) begin
      mem[tgt] <= wr_entry;
    end
    if (cmd.commit) begin
      res_item <= rsp;
    end
  end

`ifndef SYNTHESIS
  a_total_matches_valid: assert property (@(posedge clk) disable iff (rst)
    int'(total) == $countones(valid))
    else $error("job count differs from number of valid slots");

  a_total_bounded: assert property (@(posedge clk) disable iff (rst)
    int'(total) <= SLOTS)
    else $error("job count exceeds table size");

  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!res_valid || res_ready))
    else $error("result overwritten before it was taken");

  a_scan_order: assert property (@(posedge clk) disable iff (rst)
    (rd_live && $past(rd_live)) |-> (rd_idx == $past(rd_idx) + IW'(1)))
    else $error("scan skipped a slot");
`endif

endmodule

// ===== hw/rtl/edf_job_table_unit.sv =====
// Top level of the earliest-deadline-first job table.
// Holds up to SLOTS jobs. Insert, pick and pop-oldest each walk every slot once through the
// single-read job memory, in the scan and drain states, before the result is registered in
// the finish state. Remove reads only the valid bit and goes from accept straight to finish.
// One request is worked on at a time; a new one is taken while the previous result still
// waits in the output register, and its own result is held back until that one has been
// taken. Slot valid bits are flip-flops cleared by reset, so the table is usable in the
// cycle after reset with no clearing pass.
module edf_job_table_unit #(
  parameter int SLOTS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  edfjt_pkg::req_t  req_item,
  output logic             res_valid,
  input  logic             res_ready,
  output edfjt_pkg::rsp_t  res_item
);
  import edfjt_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  edfjt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .mode      (req_item.mode),
    .sts       (sts),
    .cmd       (cmd)
  );

  edfjt_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req_item  (req_item),
    .cmd       (cmd),
    .sts       (sts),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item)
  );

endmodule
